>>> src/smmgf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smmgf_pkg;

  localparam int ElemW = 8;

  typedef logic [ElemW-1:0] elem_t;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_CALC = 4'b0010,
    S_DONE = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  localparam elem_t GfLowPoly = 8'h1D;

  function automatic elem_t gf_mul(input elem_t x, input elem_t y);
    elem_t acc;
    elem_t xv;
    acc = '0;
    xv  = x;
    for (int b = 0; b < ElemW; b++) begin
      if (y[b]) begin
        acc = acc ^ xv;
      end
      xv = xv[ElemW-1] ? ((xv << 1) ^ GfLowPoly) : (xv << 1);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

>>> src/small_matrix_multiply_gf256_or_mod256_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Ports                      Contents
// in       slave      in_tvalid/tready/tdata     a, b, initial elements (row-major)
// out      master     out_tvalid/tready/tdata    product element, tlast on the final one
// cfg      write      cfg_we/cfg_wdata           galois_mode (reset 1)
//
// Loading takes a word whenever one is offered; the unit holds in_tready low from the
// completing word until the final result word is taken.
// Each result element reads the A/B/R memories into the one shared MAC in S_CALC,
// takes its last product and write-back in S_DONE, and is output in S_EMIT.
// Reset (synchronous, active low) returns to loading with an empty count.
// Output stalls hold the result register and pause the computation.

module small_matrix_multiply_gf256_or_mod256_unit #(
  parameter int MATRIX_SIZE = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // a_element, b_element, initial_element
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // product_element
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata   // galois_mode
);

  localparam int Elems = MATRIX_SIZE * MATRIX_SIZE;
  localparam int IdxW  = (Elems > 1) ? $clog2(Elems) : 1;
  localparam int KW    = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Elems - 1);
  localparam logic [KW-1:0]   LastK   = KW'(MATRIX_SIZE - 1);

  smmgf_pkg::state_t state_r, state_nxt;

  logic                   mode_r;
  logic [IdxW-1:0]        load_cnt_r, load_cnt_nxt;
  logic [KW-1:0]          row_r, row_nxt;
  logic [KW-1:0]          col_r, col_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic                   rd_vld_r;
  logic                   rd_first_r;
  smmgf_pkg::elem_t       acc_r;
  smmgf_pkg::elem_t       out_data_r;
  logic                   out_vld_r, out_vld_nxt;
  logic                   out_last_r;

  smmgf_pkg::elem_t       left_mem  [Elems];
  smmgf_pkg::elem_t       right_mem [Elems];
  smmgf_pkg::elem_t       accum_mem [Elems];
  smmgf_pkg::elem_t       a_rd_r, b_rd_r, r_rd_r;

  logic                   in_fire;
  logic                   out_fire;
  logic                   issue;
  logic                   last_elem;
  logic [IdxW-1:0]        a_addr, b_addr, r_addr;
  logic [IdxW-1:0]        acc_wr_addr;
  logic                   acc_we;
  smmgf_pkg::elem_t       acc_wdata;
  smmgf_pkg::elem_t       acc_base;
  smmgf_pkg::elem_t       int_prod;
  smmgf_pkg::elem_t       mac_val;
  logic [15:0]            int_full;

  assign in_tready  = (state_r == smmgf_pkg::S_LOAD);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_fire   = out_vld_r && out_tready;
  assign issue      = (state_r == smmgf_pkg::S_CALC);
  assign last_elem  = (row_r == LastK) && (col_r == LastK);

  assign a_addr = IdxW'(int'(row_r) * MATRIX_SIZE + int'(k_r));
  assign b_addr = IdxW'(int'(k_r) * MATRIX_SIZE + int'(col_r));
  assign r_addr = IdxW'(int'(row_r) * MATRIX_SIZE + int'(col_r));

  // accumulator memory: no read whose data is used overlaps a write
  assign acc_we      = in_fire || (state_r == smmgf_pkg::S_DONE);
  assign acc_wr_addr = in_fire ? load_cnt_r : r_addr;
  assign acc_wdata   = in_fire ? in_tdata[23:16] : mac_val;

  assign int_full = {8'd0, a_rd_r} * {8'd0, b_rd_r};
  assign int_prod = int_full[7:0];
  assign acc_base = rd_first_r ? r_rd_r : acc_r;
  assign mac_val  = mode_r ? (acc_base ^ smmgf_pkg::gf_mul(a_rd_r, b_rd_r))
                           : (acc_base + int_prod);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      left_mem[load_cnt_r]  <= in_tdata[7:0];
      right_mem[load_cnt_r] <= in_tdata[15:8];
    end
    if (acc_we) begin
      accum_mem[acc_wr_addr] <= acc_wdata;
    end
    a_rd_r <= left_mem[a_addr];
    b_rd_r <= right_mem[b_addr];
    r_rd_r <= accum_mem[r_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    k_nxt        = k_r;
    out_vld_nxt  = out_vld_r;
    unique case (state_r)
      smmgf_pkg::S_LOAD: begin
        if (in_fire) begin
          if (load_cnt_r == LastIdx) begin
            load_cnt_nxt = '0;
            row_nxt      = '0;
            col_nxt      = '0;
            k_nxt        = '0;
            state_nxt    = smmgf_pkg::S_CALC;
          end else begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
        end
      end
      smmgf_pkg::S_CALC: begin
        if (k_r == LastK) begin
          k_nxt     = '0;
          state_nxt = smmgf_pkg::S_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      smmgf_pkg::S_DONE: begin
        out_vld_nxt = 1'b1;
        state_nxt   = smmgf_pkg::S_EMIT;
      end
      smmgf_pkg::S_EMIT: begin
        if (out_fire) begin
          out_vld_nxt = 1'b0;
          if (last_elem) begin
            state_nxt = smmgf_pkg::S_LOAD;
          end else begin
            state_nxt = smmgf_pkg::S_CALC;
            if (col_r == LastK) begin
              col_nxt = '0;
              row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = smmgf_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= smmgf_pkg::S_LOAD;
      mode_r     <= 1'b1;
      load_cnt_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
      k_r        <= '0;
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      k_r        <= k_nxt;
      rd_vld_r   <= issue;
      rd_first_r <= issue && (k_r == '0);
      out_vld_r  <= out_vld_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      acc_r <= mac_val;
    end
    if (state_r == smmgf_pkg::S_DONE) begin
      out_data_r <= mac_val;
      out_last_r <= last_elem;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_vld_r))
    else $error("input accepted while a result is pending");

  assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == smmgf_pkg::S_CALC))
    else $error("read data valid without an issued read");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smmgf_pkg::S_DONE) |-> rd_vld_r)
    else $error("element finished without its last product");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_r) |=> (in_tready && load_cnt_r == '0))
    else $error("frame end did not return to loading");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != smmgf_pkg::S_LOAD) |-> (load_cnt_r == '0))
    else $error("load count nonzero outside loading");

endmodule

`default_nettype wire

>>> dv/matmul_checker.sv
`timescale 1ns / 1ps

module matmul_checker #(
  parameter int Dim = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // a_element, b_element, initial_element
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // product_element
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_wdata,  // galois_mode
  output int          mismatches,
  output int          outstanding
);

  localparam int Cells = Dim * Dim;

  typedef struct packed {
    smmgf_pkg::elem_t value;
    logic             last;
  } product_t;

  smmgf_pkg::elem_t lhs [Cells];
  smmgf_pkg::elem_t rhs [Cells];
  smmgf_pkg::elem_t accum [Cells];
  int               fill;
  logic             gf_on;
  product_t         product_q [$];
  int               errs = 0;
  int               words_seen;

  // multiply in GF(2^8), most significant bit of y first
  function automatic smmgf_pkg::elem_t gf_times(input smmgf_pkg::elem_t x,
                                                input smmgf_pkg::elem_t y);
    smmgf_pkg::elem_t acc;
    acc = '0;
    for (int b = smmgf_pkg::ElemW - 1; b >= 0; b--) begin
      acc = {acc[smmgf_pkg::ElemW-2:0], 1'b0} ^
            (acc[smmgf_pkg::ElemW-1] ? smmgf_pkg::GfLowPoly : smmgf_pkg::elem_t'(0));
      if (y[b]) begin
        acc = acc ^ x;
      end
    end
    return acc;
  endfunction

  task automatic report(input string what);
    errs++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic absorb_word(input logic [23:0] w);
    smmgf_pkg::elem_t sum;
    smmgf_pkg::elem_t term;
    product_t         item;
    lhs[fill]   = w[7:0];
    rhs[fill]   = w[15:8];
    accum[fill] = w[23:16];
    fill++;
    if (fill == Cells) begin
      fill = 0;
      for (int i = 0; i < Dim; i++) begin
        for (int j = 0; j < Dim; j++) begin
          sum = accum[i*Dim+j];
          for (int k = 0; k < Dim; k++) begin
            if (gf_on) begin
              term = gf_times(lhs[i*Dim+k], rhs[k*Dim+j]);
              sum  = sum ^ term;
            end else begin
              term = lhs[i*Dim+k] * rhs[k*Dim+j];
              sum  = sum + term;
            end
          end
          accum[i*Dim+j] = sum;
          item.value = sum;
          item.last  = (i == Dim - 1) && (j == Dim - 1);
          product_q.push_back(item);
        end
      end
    end
  endtask

  task automatic compare_product();
    product_t want;
    if (product_q.size() == 0) begin
      report($sformatf("unexpected word %02h last %0b", out_tdata, out_tlast));
    end else begin
      want = product_q.pop_front();
      if (out_tdata !== want.value) begin
        report($sformatf("word %0d product %02h, expected %02h",
                         words_seen, out_tdata, want.value));
      end
      if (out_tlast !== want.last) begin
        report($sformatf("word %0d last %0b, expected %0b",
                         words_seen, out_tlast, want.last));
      end
    end
    words_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill       = 0;
      gf_on      = 1'b1;
      words_seen = 0;
      product_q.delete();
    end else begin
      if (cfg_we) begin
        gf_on = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        compare_product();
      end
      if (in_tvalid && in_tready) begin
        absorb_word(in_tdata);
      end
    end
    outstanding <= product_q.size();
    mismatches  <= errs;
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int MatDim  = 4;
  localparam int Cells   = MatDim * MatDim;
  localparam int Settle  = 100;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_SPARSE
  } fill_kind_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // a_element, b_element, initial_element
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // product_element
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0; // galois_mode
  int          mismatches;
  int          outstanding;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  small_matrix_multiply_gf256_or_mod256_unit #(
    .MATRIX_SIZE(MatDim)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  matmul_checker #(
    .Dim(MatDim)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  function automatic smmgf_pkg::elem_t pick_byte(input fill_kind_t kind);
    case (kind)
      FILL_ZERO:   return 8'h00;
      FILL_ONES:   return 8'hFF;
      FILL_SPARSE: return ($urandom_range(0, 2) == 0) ? 8'h00 :
                          smmgf_pkg::elem_t'(1 << $urandom_range(0, 7));
      default:     return smmgf_pkg::elem_t'($urandom);
    endcase
  endfunction

  task automatic send_word(input smmgf_pkg::elem_t a, input smmgf_pkg::elem_t b,
                           input smmgf_pkg::elem_t r, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, b, a};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_frame();
    fill_kind_t kind;
    bit         no_gap;
    int         roll;
    roll   = $urandom_range(0, 9);
    kind   = (roll < 6) ? FILL_RANDOM : (roll == 6) ? FILL_ZERO :
             (roll == 7) ? FILL_ONES : FILL_SPARSE;
    no_gap = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < Cells; k++) begin
      send_word(pick_byte(kind), pick_byte(kind), pick_byte(kind), no_gap);
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_mode(input logic gf);
    cfg_we    <= 1'b1;
    cfg_wdata <= gf;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // result side: random stall per word, calm stretches, one long hold
  initial begin
    int gap;
    int calm;
    int taken;
    calm  = 0;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (calm > 0) begin
        gap = 0;
        calm--;
      end else begin
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 7) == 0) begin
          calm = 40;
        end
      end
      if (taken == 3 * Cells + 5) begin
        gap = 600;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      taken++;
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes in the power-up mode: full bytes, top bit only, zeros
    for (int k = 0; k < Cells; k++) begin
      send_word((k % 3 == 0) ? 8'hFF : (k % 3 == 1) ? 8'h80 : 8'h00,
                k[1] ? 8'hFF : 8'h80,
                k[0] ? 8'hFF : 8'h00,
                1'b0);
    end
    in_tvalid <= 1'b0;

    // first batch of four frames keeps input offered during the long output hold
    for (int p = 0; p < 11; p++) begin
      wait_idle();
      write_mode((p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom));
      repeat ((p == 0) ? 4 : $urandom_range(1, 4)) send_frame();
      in_tvalid <= 1'b0;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/smmgf_pkg.sv
src/small_matrix_multiply_gf256_or_mod256_unit.sv
dv/matmul_checker.sv
dv/tb_top.sv
